// ===== rtl/unix_seconds_to_calendar_assert.svh =====
// Assertion macros used by the calendar conversion RTL.
`ifndef UNIX_SECONDS_TO_CALENDAR_ASSERT_SVH
`define UNIX_SECONDS_TO_CALENDAR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define USTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define USTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define USTC_ASSERT(lbl, prop, msg)
`define USTC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/ustc_pkg.sv =====
// Types, constants and the month table of the calendar conversion.
`default_nettype none

package ustc_pkg;

  localparam int unsigned Stages = 12;

  localparam logic [63:0] OffsetDays = 64'd3181458;
  localparam logic [63:0] EpochDays  = 64'd4 * 64'd146097 + 64'd369 * 64'd365 + 64'd72 + 64'd17;

  localparam logic [39:0] OffsetSec = 40'(OffsetDays * 64'd86400);
  localparam logic [23:0] DayBias   = 24'(OffsetDays - EpochDays);

  localparam logic signed [38:0] TimeMin = -39'sd62135596800;
  localparam logic signed [38:0] TimeMax = 39'sd253402300799;

  localparam logic [9:0]  SubDay      = 10'd675;
  localparam logic [23:0] RecipSubDay = 24'((64'd1 << 33) / 64'd675);
  localparam logic [11:0] SecHour     = 12'd3600;
  localparam logic [5:0]  RecipHour   = 6'((64'd1 << 17) / 64'd3600);
  localparam logic [5:0]  SecMin      = 6'd60;
  localparam logic [6:0]  RecipMin    = 7'((64'd1 << 12) / 64'd60);
  localparam logic [17:0] Days400     = 18'd146097;
  localparam logic [4:0]  Recip400    = 5'((64'd1 << 22) / 64'd146097);
  localparam logic [15:0] Days100     = 16'd36524;
  localparam logic [10:0] Days4       = 11'd1461;
  localparam logic [5:0]  Recip4      = 6'((64'd1 << 16) / 64'd1461);
  localparam logic [8:0]  DaysYear    = 9'd365;

  typedef struct packed {
    logic signed [38:0] unix_seconds;
  } ustc_in_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        out_of_range;
  } ustc_out_t;

  typedef struct packed {
    logic [Stages-1:0] load;
    logic [Stages-1:0] valid;
    logic              in_ready;
    logic              out_valid;
  } ustc_pipe_t;

  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    base = '0;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (idx >= 4'd2) begin
      base = base + 9'(leap);
    end
    return base;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ustc_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transaction.
`default_nettype none

interface ustc_stream_if #(
  parameter type PayloadT = logic
);
  logic    valid;
  logic    ready;
  PayloadT data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ustc_pipe_ctrl.sv =====
// Valid tracking and per-stage load enables of the conversion pipeline.
`default_nettype none

module ustc_pipe_ctrl
  import ustc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic out_ready_i,
  output ustc_pipe_t pipe_o
);

  localparam logic [Stages-1:0] AllOnes = '1;

  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] valid_d;
  logic [Stages-1:0] ready;

  // A stage may load when out_ready_i is high or any stage at or after it has a hole.
  always_comb begin
    for (int k = 0; k < Stages; k++) begin
      ready[k] = out_ready_i || ((valid_q >> k) != (AllOnes >> k));
    end
  end

  always_comb begin
    valid_d = (ready & {valid_q[Stages-2:0], in_valid_i}) | (~ready & valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_comb begin
    pipe_o.load      = ready;
    pipe_o.valid     = valid_q;
    pipe_o.in_ready  = ready[0];
    pipe_o.out_valid = valid_q[Stages-1];
  end

endmodule

`default_nettype wire

// ===== rtl/unix_seconds_to_calendar.sv =====
// Top level: signed Unix seconds to proleptic Gregorian date and time of day.
// Each transaction on in_i carries a 39-bit signed second count; the matching
// transaction on out_o carries year, month, day, hour, minute, second and an
// out_of_range flag, in input order. The block accepts one transaction per
// cycle while in_i.ready is high and returns results through a twelve-stage
// pipeline of reciprocal-multiply and correction steps (days, 400/100/4/1-year
// cycles, month search). Stalls on out_o back up stage by stage, filling any
// holes first. Times outside years 1 to 9999 give out_of_range with a zero
// date and the floor-based time of day.
`default_nettype none
`include "unix_seconds_to_calendar_assert.svh"

module unix_seconds_to_calendar
  import ustc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ustc_stream_if.sink    in_i,
  ustc_stream_if.source  out_o
);

  ustc_pipe_t pipe;

  ustc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .pipe_o      (pipe)
  );

  // Stage 1: bias to a non-negative count, range check.
  logic [39:0] u_s1_q;
  logic        oor_s1_q;
  // Stage 2: day quotient estimate.
  logic [23:0] qe_s2_q;
  logic [10:0] vlo_s2_q;
  logic [6:0]  slo_s2_q;
  logic        oor_s2_q;
  // Stage 3: corrected day count and seconds of day.
  logic [23:0] q_s3_q;
  logic [16:0] sod_s3_q;
  logic        oor_s3_q;
  // Stage 4
  logic [21:0] d_s4_q;
  logic [16:0] sod_s4_q;
  logic [4:0]  he_s4_q;
  logic        oor_s4_q;
  // Stage 5
  logic [21:0] d_s5_q;
  logic [4:0]  n400e_s5_q;
  logic [4:0]  hour_s5_q;
  logic [11:0] remh_s5_q;
  logic        oor_s5_q;
  // Stage 6
  logic [4:0]  n400_s6_q;
  logic [17:0] d1_s6_q;
  logic [5:0]  me_s6_q;
  logic [11:0] remh_s6_q;
  logic [4:0]  hour_s6_q;
  logic        oor_s6_q;
  // Stage 7
  logic [4:0]  n400_s7_q;
  logic [1:0]  c_s7_q;
  logic [15:0] d2_s7_q;
  logic [4:0]  hour_s7_q;
  logic [5:0]  min_s7_q;
  logic [5:0]  sec_s7_q;
  logic        oor_s7_q;
  // Stage 8
  logic [4:0]  n400_s8_q;
  logic [1:0]  c_s8_q;
  logic [15:0] d2_s8_q;
  logic [4:0]  n4e_s8_q;
  logic [4:0]  hour_s8_q;
  logic [5:0]  min_s8_q;
  logic [5:0]  sec_s8_q;
  logic        oor_s8_q;
  // Stage 9
  logic [4:0]  n400_s9_q;
  logic [1:0]  c_s9_q;
  logic [4:0]  n4_s9_q;
  logic [10:0] d3_s9_q;
  logic [4:0]  hour_s9_q;
  logic [5:0]  min_s9_q;
  logic [5:0]  sec_s9_q;
  logic        oor_s9_q;
  // Stage 10
  logic [4:0]  n400_s10_q;
  logic [1:0]  c_s10_q;
  logic [4:0]  n4_s10_q;
  logic [1:0]  y_s10_q;
  logic [8:0]  d4_s10_q;
  logic        leap_s10_q;
  logic [4:0]  hour_s10_q;
  logic [5:0]  min_s10_q;
  logic [5:0]  sec_s10_q;
  logic        oor_s10_q;
  // Stage 11
  logic [13:0] year_s11_q;
  logic [3:0]  mon_s11_q;
  logic [8:0]  d4_s11_q;
  logic        leap_s11_q;
  logic [4:0]  hour_s11_q;
  logic [5:0]  min_s11_q;
  logic [5:0]  sec_s11_q;
  logic        oor_s11_q;
  // Stage 12: output register.
  ustc_out_t   out_q;

  // Combinational step values.
  logic [39:0] u_d;
  logic        oor_d;
  logic [56:0] day_prod;
  logic [10:0] sub_lo;
  logic [10:0] r3;
  logic [23:0] q_d;
  logic [9:0]  rem_d;
  logic [21:0] hour_prod;
  logic [26:0] n400_prod;
  logic [16:0] r5;
  logic [4:0]  hour_d;
  logic [11:0] remh_d;
  logic [21:0] r6;
  logic [4:0]  n400_d;
  logic [17:0] d1_d;
  logic [17:0] min_prod;
  logic [1:0]  c_d;
  logic [15:0] d2_d;
  logic [11:0] r7m;
  logic [5:0]  min_d;
  logic [5:0]  sec_d;
  logic [20:0] n4_prod;
  logic [15:0] r9;
  logic [4:0]  n4_d;
  logic [10:0] d3_d;
  logic [1:0]  y_d;
  logic [8:0]  d4_d;
  logic        leap_d;
  logic [3:0]  mon_d;
  logic [13:0] year_d;
  logic [8:0]  dom_d;
  ustc_out_t   out_d;

  always_comb begin
    u_d   = {in_i.data.unix_seconds[38], in_i.data.unix_seconds} + OffsetSec;
    oor_d = (in_i.data.unix_seconds < TimeMin) || (in_i.data.unix_seconds > TimeMax);

    day_prod = 57'(u_s1_q[39:7]) * 57'(RecipSubDay);

    sub_lo = qe_s2_q[10:0] * 11'(SubDay);
    r3     = vlo_s2_q - sub_lo;
    if (r3 >= 11'(SubDay)) begin
      q_d   = qe_s2_q + 24'd1;
      rem_d = 10'(r3 - 11'(SubDay));
    end else begin
      q_d   = qe_s2_q;
      rem_d = 10'(r3);
    end

    hour_prod = 22'(sod_s3_q) * 22'(RecipHour);

    n400_prod = 27'(d_s4_q) * 27'(Recip400);
    r5        = sod_s4_q - 17'(he_s4_q) * 17'(SecHour);
    if (r5 >= 17'(SecHour)) begin
      hour_d = he_s4_q + 5'd1;
      remh_d = 12'(r5 - 17'(SecHour));
    end else begin
      hour_d = he_s4_q;
      remh_d = 12'(r5);
    end

    r6 = d_s5_q - 22'(n400e_s5_q) * 22'(Days400);
    if (r6 >= 22'(Days400)) begin
      n400_d = n400e_s5_q + 5'd1;
      d1_d   = 18'(r6 - 22'(Days400));
    end else begin
      n400_d = n400e_s5_q;
      d1_d   = 18'(r6);
    end
    min_prod = 18'(remh_s5_q) * 18'(RecipMin);

    // Keep the last day of a 400-year cycle in its final century.
    if (d1_s6_q >= 18'(Days100) * 18'd3) begin
      c_d = 2'd3;
    end else if (d1_s6_q >= 18'(Days100) * 18'd2) begin
      c_d = 2'd2;
    end else if (d1_s6_q >= 18'(Days100)) begin
      c_d = 2'd1;
    end else begin
      c_d = 2'd0;
    end
    d2_d = 16'(d1_s6_q - 18'(c_d) * 18'(Days100));
    r7m  = remh_s6_q - 12'(me_s6_q) * 12'(SecMin);
    if (r7m >= 12'(SecMin)) begin
      min_d = me_s6_q + 6'd1;
      sec_d = 6'(r7m - 12'(SecMin));
    end else begin
      min_d = me_s6_q;
      sec_d = 6'(r7m);
    end

    n4_prod = 21'(d2_s7_q) * 21'(Recip4);

    r9 = d2_s8_q - 16'(n4e_s8_q) * 16'(Days4);
    if (r9 >= 16'(Days4)) begin
      n4_d = n4e_s8_q + 5'd1;
      d3_d = 11'(r9 - 16'(Days4));
    end else begin
      n4_d = n4e_s8_q;
      d3_d = 11'(r9);
    end

    // Keep the leap day of a 4-year cycle in its final year.
    if (d3_s9_q >= 11'(DaysYear) * 11'd3) begin
      y_d = 2'd3;
    end else if (d3_s9_q >= 11'(DaysYear) * 11'd2) begin
      y_d = 2'd2;
    end else if (d3_s9_q >= 11'(DaysYear)) begin
      y_d = 2'd1;
    end else begin
      y_d = 2'd0;
    end
    d4_d   = 9'(d3_s9_q - 11'(y_d) * 11'(DaysYear));
    leap_d = (y_d == 2'd3) && ((n4_s9_q != 5'd24) || (c_s9_q == 2'd3));

    mon_d = '0;
    for (int i = 1; i < 12; i++) begin
      if (d4_s10_q >= month_start(4'(i), leap_s10_q)) begin
        mon_d = 4'(i);
      end
    end
    year_d = 14'd1 + 14'(n400_s10_q) * 14'd400 + 14'(c_s10_q) * 14'd100
           + 14'({n4_s10_q, 2'b00}) + 14'(y_s10_q);

    dom_d = d4_s11_q - month_start(mon_s11_q, leap_s11_q) + 9'd1;
    out_d.hour         = hour_s11_q;
    out_d.minute       = min_s11_q;
    out_d.second       = sec_s11_q;
    out_d.out_of_range = oor_s11_q;
    if (oor_s11_q) begin
      out_d.year  = '0;
      out_d.month = '0;
      out_d.day   = '0;
    end else begin
      out_d.year  = year_s11_q;
      out_d.month = mon_s11_q + 4'd1;
      out_d.day   = 5'(dom_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe.load[0]) begin
      u_s1_q   <= u_d;
      oor_s1_q <= oor_d;
    end
    if (pipe.load[1]) begin
      qe_s2_q  <= day_prod[56:33];
      vlo_s2_q <= u_s1_q[17:7];
      slo_s2_q <= u_s1_q[6:0];
      oor_s2_q <= oor_s1_q;
    end
    if (pipe.load[2]) begin
      q_s3_q   <= q_d;
      sod_s3_q <= {rem_d, slo_s2_q};
      oor_s3_q <= oor_s2_q;
    end
    if (pipe.load[3]) begin
      d_s4_q   <= 22'(q_s3_q - DayBias);
      sod_s4_q <= sod_s3_q;
      he_s4_q  <= hour_prod[21:17];
      oor_s4_q <= oor_s3_q;
    end
    if (pipe.load[4]) begin
      d_s5_q     <= d_s4_q;
      n400e_s5_q <= n400_prod[26:22];
      hour_s5_q  <= hour_d;
      remh_s5_q  <= remh_d;
      oor_s5_q   <= oor_s4_q;
    end
    if (pipe.load[5]) begin
      n400_s6_q <= n400_d;
      d1_s6_q   <= d1_d;
      me_s6_q   <= min_prod[17:12];
      remh_s6_q <= remh_s5_q;
      hour_s6_q <= hour_s5_q;
      oor_s6_q  <= oor_s5_q;
    end
    if (pipe.load[6]) begin
      n400_s7_q <= n400_s6_q;
      c_s7_q    <= c_d;
      d2_s7_q   <= d2_d;
      hour_s7_q <= hour_s6_q;
      min_s7_q  <= min_d;
      sec_s7_q  <= sec_d;
      oor_s7_q  <= oor_s6_q;
    end
    if (pipe.load[7]) begin
      n400_s8_q <= n400_s7_q;
      c_s8_q    <= c_s7_q;
      d2_s8_q   <= d2_s7_q;
      n4e_s8_q  <= n4_prod[20:16];
      hour_s8_q <= hour_s7_q;
      min_s8_q  <= min_s7_q;
      sec_s8_q  <= sec_s7_q;
      oor_s8_q  <= oor_s7_q;
    end
    if (pipe.load[8]) begin
      n400_s9_q <= n400_s8_q;
      c_s9_q    <= c_s8_q;
      n4_s9_q   <= n4_d;
      d3_s9_q   <= d3_d;
      hour_s9_q <= hour_s8_q;
      min_s9_q  <= min_s8_q;
      sec_s9_q  <= sec_s8_q;
      oor_s9_q  <= oor_s8_q;
    end
    if (pipe.load[9]) begin
      n400_s10_q <= n400_s9_q;
      c_s10_q    <= c_s9_q;
      n4_s10_q   <= n4_s9_q;
      y_s10_q    <= y_d;
      d4_s10_q   <= d4_d;
      leap_s10_q <= leap_d;
      hour_s10_q <= hour_s9_q;
      min_s10_q  <= min_s9_q;
      sec_s10_q  <= sec_s9_q;
      oor_s10_q  <= oor_s9_q;
    end
    if (pipe.load[10]) begin
      year_s11_q <= year_d;
      mon_s11_q  <= mon_d;
      d4_s11_q   <= d4_s10_q;
      leap_s11_q <= leap_s10_q;
      hour_s11_q <= hour_s10_q;
      min_s11_q  <= min_s10_q;
      sec_s11_q  <= sec_s10_q;
      oor_s11_q  <= oor_s10_q;
    end
    if (pipe.load[11]) begin
      out_q <= out_d;
    end
  end

  assign in_i.ready  = pipe.in_ready;
  assign out_o.valid = pipe.out_valid;
  assign out_o.data  = out_q;

  `USTC_ASSERT(a_oor_date_zero, out_o.valid && out_o.data.out_of_range |-> out_o.data.year == 14'd0 && out_o.data.month == 4'd0 && out_o.data.day == 5'd0, "out of range result carries a date")
  `USTC_ASSERT(a_date_legal, out_o.valid && !out_o.data.out_of_range |-> out_o.data.year != 14'd0 && out_o.data.month >= 4'd1 && out_o.data.month <= 4'd12 && out_o.data.day >= 5'd1 && out_o.data.day <= 5'd31, "illegal calendar date")
  `USTC_ASSERT(a_time_legal, out_o.valid |-> out_o.data.hour <= 5'd23 && out_o.data.minute <= 6'd59 && out_o.data.second <= 6'd59, "illegal time of day")
  `USTC_ASSERT_NEXT(a_accept_fills, in_i.valid && in_i.ready, pipe.valid[0], "accepted transaction did not enter the pipeline")

endmodule

`default_nettype wire
